### design/coc_pkg.sv
// Shared types and constants for the circle-of-confusion radius pipeline.
package coc_pkg;

  localparam int DW = 63;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_PHYS = 2'd1;
  localparam logic [1:0] MODE_ART  = 2'd2;

  localparam logic [3:0] CFG_MODE      = 4'd0;
  localparam logic [3:0] CFG_LENS      = 4'd1;
  localparam logic [3:0] CFG_FOCUS     = 4'd2;
  localparam logic [3:0] CFG_NEAR_SHRP = 4'd3;
  localparam logic [3:0] CFG_NEAR_BLUR = 4'd4;
  localparam logic [3:0] CFG_FAR_SHRP  = 4'd5;
  localparam logic [3:0] CFG_FAR_BLUR  = 4'd6;
  localparam logic [3:0] CFG_FRACS     = 4'd7;

  localparam logic [30:0] RST_LENS      = 31'd655;
  localparam logic [31:0] RST_FOCUS     = 32'hFFF6_0000;
  localparam logic [31:0] RST_NEAR_SHRP = 32'hFFFF_0000;
  localparam logic [31:0] RST_NEAR_BLUR = 32'hFFFF_C000;
  localparam logic [31:0] RST_FAR_SHRP  = 32'hFFD8_0000;
  localparam logic [31:0] RST_FAR_BLUR  = 32'hFF9C_0000;
  localparam logic [31:0] RST_FRACS     = 32'h0148_03D7;

  localparam logic [31:0] SAT_POS  = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG  = 32'h8000_0000;
  localparam logic [31:0] ONE_Q16  = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [30:0] lens;
    logic [31:0] focus;
    logic [31:0] near_shrp;
    logic [31:0] near_blur;
    logic [31:0] far_shrp;
    logic [31:0] far_blur;
    logic [31:0] fracs;
  } cfg_t;

  typedef struct packed {
    logic zero;
    logic neg;
    logic bad;
    logic ovf;
  } side_t;

endpackage

### design/coc_front.sv
// Operand selection and multiplier stages producing dividend and divisor.
module coc_front import coc_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int NW = 95
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [31:0]   depth_z,
  input  logic [31:0]   ppm,
  input  logic [15:0]   screen,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [NW-1:0] num,
  output logic [DW-1:0] den,
  output side_t         side
);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  logic [31:0] m1a, m1a_next;
  logic [30:0] m1b, m1b_next;
  logic [31:0] m2, m2_next;
  logic [31:0] da, da_next;
  logic [31:0] db, db_next;
  logic        art1, art1_next;
  side_t       side1, side1_next;

  logic [62:0] p1;
  logic [63:0] den2;
  logic [31:0] m2_2;
  logic        art2;
  side_t       side2;

  logic [63:0] pl;
  logic [62:0] ph;
  logic [63:0] den3;
  logic        art3;
  side_t       side3;

  logic signed [32:0] zx, fx, diff;
  logic [31:0] absdiff, absf, absz;
  logic [31:0] nlim, flim;
  logic [32:0] nn, nd, fn, fd;
  logic        near_hit, far_hit, near_degen, far_degen;
  logic [NW-1:0] sum4;

  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v4;

  always_comb begin
    zx = {depth_z[31], depth_z};
    fx = {cfg.focus[31], cfg.focus};
    diff = zx - fx;
    absdiff = diff[32] ? 32'(-diff) : diff[31:0];
    absf = cfg.focus[31] ? 32'(-fx) : cfg.focus;
    absz = depth_z[31] ? 32'(-zx) : depth_z;
    near_hit = $signed(depth_z) >= $signed(cfg.near_shrp);
    far_hit = $signed(depth_z) <= $signed(cfg.far_shrp);
    near_degen = $signed(cfg.near_blur) <= $signed(cfg.near_shrp);
    far_degen = $signed(cfg.far_blur) >= $signed(cfg.far_shrp);
    nlim = ($signed(depth_z) < $signed(cfg.near_blur)) ? depth_z : cfg.near_blur;
    flim = ($signed(depth_z) > $signed(cfg.far_blur)) ? depth_z : cfg.far_blur;
    nn = {nlim[31], nlim} - {cfg.near_shrp[31], cfg.near_shrp};
    nd = {cfg.near_blur[31], cfg.near_blur} - {cfg.near_shrp[31], cfg.near_shrp};
    fn = {cfg.far_shrp[31], cfg.far_shrp} - {flim[31], flim};
    fd = {cfg.far_shrp[31], cfg.far_shrp} - {cfg.far_blur[31], cfg.far_blur};

    m1a_next = '0;
    m1b_next = '0;
    m2_next = '0;
    da_next = '0;
    db_next = '0;
    art1_next = 1'b0;
    side1_next = '0;
    unique case (cfg.mode)
      MODE_PHYS: begin
        side1_next.bad = !depth_z[31];
        side1_next.zero = !depth_z[31] || (cfg.focus == '0);
        side1_next.neg = diff[32] ^ cfg.focus[31];
        m1a_next = absdiff;
        m1b_next = cfg.lens;
        m2_next = ppm;
        da_next = absf;
        db_next = absz;
      end
      MODE_ART: begin
        art1_next = 1'b1;
        m2_next = {16'd0, screen};
        db_next = ONE_Q16;
        if (near_hit) begin
          m1b_next = {15'd0, cfg.fracs[15:0]};
          m1a_next = near_degen ? 32'd1 : nn[31:0];
          da_next = near_degen ? 32'd1 : nd[31:0];
        end else if (far_hit) begin
          m1b_next = {15'd0, cfg.fracs[31:16]};
          m1a_next = far_degen ? 32'd1 : fn[31:0];
          da_next = far_degen ? 32'd1 : fd[31:0];
        end else begin
          side1_next.zero = 1'b1;
          da_next = 32'd1;
        end
      end
      default: begin
        side1_next.zero = 1'b1;
      end
    endcase
  end

  always_comb begin
    sum4 = NW'({ph, 32'd0}) + NW'(pl);
    if (art3) begin
      sum4 = sum4 << FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      m1a <= m1a_next;
      m1b <= m1b_next;
      m2 <= m2_next;
      da <= da_next;
      db <= db_next;
      art1 <= art1_next;
      side1 <= side1_next;
    end
    if (en2) begin
      p1 <= m1a * m1b;
      den2 <= da * db;
      m2_2 <= m2;
      art2 <= art1;
      side2 <= side1;
    end
    if (en3) begin
      pl <= p1[31:0] * m2_2;
      ph <= p1[62:32] * m2_2;
      den3 <= den2;
      art3 <= art2;
      side3 <= side2;
    end
    if (en4) begin
      num <= sum4;
      den <= den3[DW-1:0];
      side <= side3;
    end
  end

endmodule

### design/coc_div.sv
// Pipelined restoring divider: the first stage flags overflow, then one quotient bit per stage.
module coc_div import coc_pkg::*; #(
  parameter int NW = 95
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  side_t         side_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [30:0]   quot,
  output side_t         side_out
);

  localparam int STAGES = 32;

  logic          v   [STAGES];
  logic          en  [STAGES];
  logic [NW-1:0] rem [STAGES];
  logic [30:0]   q   [STAGES];
  logic [DW-1:0] dd  [STAGES];
  side_t         sd  [STAGES];
  side_t         side0;

  assign en[STAGES-1] = !v[STAGES-1] || out_ready;
  assign in_ready = en[0];
  assign out_valid = v[STAGES-1];
  assign quot = q[STAGES-1];
  assign side_out = sd[STAGES-1];

  // first stage flags a quotient of 2^31 or more
  always_comb begin
    side0 = side_in;
    side0.ovf = num >= (NW'(den) << 31);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0] <= num;
      q[0] <= '0;
      dd[0] <= den;
      sd[0] <= side0;
    end
  end

  for (genvar k = 1; k < STAGES; k++) begin : g_stage
    logic [NW-1:0] trial;
    logic          ge;

    assign en[k-1] = !v[k-1] || en[k];
    assign trial = NW'(dd[k-1]) << (STAGES - 1 - k);
    assign ge = rem[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k] <= ge ? rem[k-1] - trial : rem[k-1];
        q[k] <= {q[k-1][29:0], ge};
        dd[k] <= dd[k-1];
        sd[k] <= sd[k-1];
      end
    end
  end

endmodule

### design/depth_of_field_coc_radius.sv
// Depth-of-field circle-of-confusion radius: one pixel per clock, when the output
// is not stalled, through a 37-stage pipeline (4 operand and multiplier stages,
// 32 divider stages, of which the first flags overflow and each later one settles
// one quotient bit, 1 output stage). Mode none gives 0; physical mode applies
// the thin-lens formula and flags depths not in front of the camera; artist
// mode ramps from the sharp planes to the blurry planes.
// Radii are truncated toward zero and saturated to signed 32 bits.
// Configuration writes take effect in the next cycle and belong while idle.
module depth_of_field_coc_radius import coc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] depth_z,
  input  logic [31:0] pixels_per_meter,
  input  logic [15:0] screen_size_px,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] radius_px,
  output logic        bad_depth
);

  localparam int NW = (65 + FRAC_BITS > 95) ? 65 + FRAC_BITS : 95;

  cfg_t          cfg;
  logic          f_valid, f_ready;
  logic [NW-1:0] f_num;
  logic [DW-1:0] f_den;
  side_t         f_side;
  logic          d_valid, d_ready;
  logic [30:0]   d_quot;
  side_t         d_side;
  logic [31:0]   radius_next;
  logic [1:0]    blur_mode;

  assign cfg_ready = 1'b1;
  assign blur_mode = cfg.mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= MODE_NONE;
      cfg.lens <= RST_LENS;
      cfg.focus <= RST_FOCUS;
      cfg.near_shrp <= RST_NEAR_SHRP;
      cfg.near_blur <= RST_NEAR_BLUR;
      cfg.far_shrp <= RST_FAR_SHRP;
      cfg.far_blur <= RST_FAR_BLUR;
      cfg.fracs <= RST_FRACS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:      cfg.mode <= cfg_data[1:0];
        CFG_LENS:      cfg.lens <= cfg_data[30:0];
        CFG_FOCUS:     cfg.focus <= cfg_data;
        CFG_NEAR_SHRP: cfg.near_shrp <= cfg_data;
        CFG_NEAR_BLUR: cfg.near_blur <= cfg_data;
        CFG_FAR_SHRP:  cfg.far_shrp <= cfg_data;
        CFG_FAR_BLUR:  cfg.far_blur <= cfg_data;
        CFG_FRACS:     cfg.fracs <= cfg_data;
        default: ;
      endcase
    end
  end

  coc_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .depth_z   (depth_z),
    .ppm       (pixels_per_meter),
    .screen    (screen_size_px),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .num       (f_num),
    .den       (f_den),
    .side      (f_side)
  );

  coc_div #(.NW(NW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .num       (f_num),
    .den       (f_den),
    .side_in   (f_side),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .quot      (d_quot),
    .side_out  (d_side)
  );

  assign d_ready = !out_valid || out_ready;

  always_comb begin
    if (d_side.zero) begin
      radius_next = '0;
    end else if (d_side.ovf) begin
      radius_next = d_side.neg ? SAT_NEG : SAT_POS;
    end else if (d_side.neg) begin
      radius_next = 32'(-{1'b0, d_quot});
    end else begin
      radius_next = {1'b0, d_quot};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (d_ready) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      radius_px <= radius_next;
      bad_depth <= d_side.bad;
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_depth |-> radius_px == '0)
    else $error("bad depth with nonzero radius");

  a_mode_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == CFG_MODE |=> blur_mode == $past(cfg_data[1:0]))
    else $error("blur mode write lost");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

### test/tb_top.sv
// Testbench for depth_of_field_coc_radius: random and directed pixels checked against a local predictor.
`timescale 1ns / 1ps

module tb_top;
  import coc_pkg::*;

  localparam int SETTLE = 60;

  typedef struct {
    logic [31:0] z;
    logic [31:0] ppm;
    logic [15:0] scr;
  } pixel_t;

  typedef struct {
    logic [31:0] radius;
    logic        bad;
  } coc_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] depth_z = '0;
  logic [31:0] pixels_per_meter = '0;
  logic [15:0] screen_size_px = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] radius_px;
  logic        bad_depth;

  // predictor's copy of the registers
  logic [1:0]  m_mode;
  longint      m_lens, m_focus, m_nshrp, m_nblur, m_fshrp, m_fblur;
  logic [31:0] m_fracs;

  pixel_t pending_px[$];
  coc_t   expected_coc[$];
  int     errors = 0;
  bit     quiet = 1'b0;
  int     in_gap = 0;
  int     out_gap = 0;

  always #5 clk = ~clk;

  depth_of_field_coc_radius u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .depth_z(depth_z),
    .pixels_per_meter(pixels_per_meter), .screen_size_px(screen_size_px),
    .out_valid(out_valid), .out_ready(out_ready), .radius_px(radius_px),
    .bad_depth(bad_depth)
  );

  task automatic report(input string msg);
    $display("tb_top: mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic longint sx(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [127:0] mag(input longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic logic [31:0] saturate(input logic [127:0] m, input bit neg);
    if (neg) begin
      if (m >= 128'h8000_0000) return SAT_NEG;
      return 32'(-m);
    end
    if (m > 128'h7FFF_FFFF) return SAT_POS;
    return m[31:0];
  endfunction

  function automatic logic [31:0] ramp(input logic [127:0] num, input logic [127:0] den,
                                       input logic [15:0] frac, input logic [15:0] scr);
    logic [127:0] top;
    top = num * 128'(frac) * (128'(scr) << 16);
    return saturate(top / (den << 16), 1'b0);
  endfunction

  function automatic coc_t coc_of(input pixel_t p);
    coc_t   r;
    longint z, d, lim;
    logic [127:0] q;
    z = sx(p.z);
    r.radius = '0;
    r.bad = 1'b0;
    if (m_mode == MODE_PHYS) begin
      if (z >= 0) r.bad = 1'b1;
      else if (m_focus != 0) begin
        d = z - m_focus;
        q = (mag(d) * 128'(m_lens) * 128'(p.ppm)) / (mag(m_focus) * mag(z));
        if (q != 0) r.radius = saturate(q, (d < 0) != (m_focus < 0));
      end
    end else if (m_mode == MODE_ART) begin
      if (z >= m_nshrp) begin
        lim = (z < m_nblur) ? z : m_nblur;
        if (m_nblur <= m_nshrp) r.radius = ramp(1, 1, m_fracs[15:0], p.scr);
        else r.radius = ramp(128'(lim - m_nshrp), 128'(m_nblur - m_nshrp),
                             m_fracs[15:0], p.scr);
      end else if (z <= m_fshrp) begin
        lim = (z > m_fblur) ? z : m_fblur;
        if (m_fblur >= m_fshrp) r.radius = ramp(1, 1, m_fracs[31:16], p.scr);
        else r.radius = ramp(128'(m_fshrp - lim), 128'(m_fshrp - m_fblur),
                             m_fracs[31:16], p.scr);
      end
    end
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    pixel_t p;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        p.z = depth_z;
        p.ppm = pixels_per_meter;
        p.scr = screen_size_px;
        expected_coc.push_back(coc_of(p));
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_px.size() > 0) begin
          p = pending_px.pop_front();
          depth_z <= p.z;
          pixels_per_meter <= p.ppm;
          screen_size_px <= p.scr;
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    coc_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_coc.size() == 0) begin
          report($sformatf("unexpected result radius %h", radius_px));
        end else begin
          e = expected_coc.pop_front();
          if (radius_px !== e.radius)
            report($sformatf("radius_px %h, want %h", radius_px, e.radius));
          if (bad_depth !== e.bad)
            report($sformatf("bad_depth %b, want %b", bad_depth, e.bad));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 11);
      end
    end
  end

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MODE:      m_mode = val[1:0];
      CFG_LENS:      m_lens = longint'(val[30:0]);
      CFG_FOCUS:     m_focus = sx(val);
      CFG_NEAR_SHRP: m_nshrp = sx(val);
      CFG_NEAR_BLUR: m_nblur = sx(val);
      CFG_FAR_SHRP:  m_fshrp = sx(val);
      CFG_FAR_BLUR:  m_fblur = sx(val);
      CFG_FRACS:     m_fracs = val;
      default: ;
    endcase
  endtask

  task automatic push(input logic [31:0] z, input logic [31:0] ppm, input logic [15:0] scr);
    pixel_t p;
    p.z = z;
    p.ppm = ppm;
    p.scr = scr;
    pending_px.push_back(p);
  endtask

  // hold until every pixel is out, then let the pipeline drain
  task automatic drain();
    while (pending_px.size() > 0 || in_valid || expected_coc.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] near_plane(input longint base);
    return 32'(base + longint'($urandom_range(0, 4096)) - 2048);
  endfunction

  function automatic logic [31:0] rand_depth();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return near_plane(m_nshrp);
      2: return near_plane(m_nblur);
      3: return near_plane(m_fshrp);
      4: return near_plane(m_fblur);
      5: return near_plane(m_focus);
      default: return -32'($urandom_range(1, 32'h0100_0000));
    endcase
  endfunction

  function automatic logic [31:0] rand_neg();
    return ($urandom_range(0, 4) == 0) ? ($urandom | 32'h8000_0000)
                                       : -32'($urandom_range(0, 32'h00A0_0000));
  endfunction

  task automatic random_phase(input int count);
    logic [31:0] ppm;
    logic [15:0] scr;
    write_reg(CFG_MODE, ($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, 3))
                                                   : 32'($urandom_range(1, 2)));
    write_reg(CFG_LENS, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 4000));
    case ($urandom_range(0, 9))
      0: write_reg(CFG_FOCUS, 32'd0);
      1: write_reg(CFG_FOCUS, $urandom);
      default: write_reg(CFG_FOCUS, -32'($urandom_range(1, 32'h0100_0000)));
    endcase
    write_reg(CFG_NEAR_SHRP, rand_neg());
    write_reg(CFG_NEAR_BLUR, rand_neg());
    write_reg(CFG_FAR_SHRP, rand_neg());
    write_reg(CFG_FAR_BLUR, rand_neg());
    write_reg(CFG_FRACS, $urandom);
    repeat (count) begin
      ppm = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000);
      scr = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
      push(rand_depth(), ppm, scr);
    end
    drain();
  endtask

  initial begin
    m_mode = MODE_NONE;
    m_lens = longint'(RST_LENS);
    m_focus = sx(RST_FOCUS);
    m_nshrp = sx(RST_NEAR_SHRP);
    m_nblur = sx(RST_NEAR_BLUR);
    m_fshrp = sx(RST_FAR_SHRP);
    m_fblur = sx(RST_FAR_BLUR);
    m_fracs = RST_FRACS;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // mode none with extreme fields
    push(32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF);
    push(32'h7FFF_FFFF, 32'd0, 16'd0);
    drain();
    // unused mode answers as none
    write_reg(CFG_MODE, 32'd3);
    push(32'hFFF0_0000, 32'h0100_0000, 16'd1920);
    drain();
    // physical, reset planes: behind focus, in front, zero and positive depth
    write_reg(CFG_MODE, 32'd1);
    push(32'hFF00_0000, 32'h0100_0000, 16'd1920);
    push(32'hFFFF_F000, 32'h0100_0000, 16'd1920);
    push(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
    push(32'd0, 32'h0100_0000, 16'd0);
    push(32'h7FFF_FFFF, 32'h0100_0000, 16'd0);
    push(32'h8000_0000, 32'hFFFF_FFFF, 16'd0);
    push(RST_FOCUS, 32'hFFFF_FFFF, 16'd0);
    drain();
    // largest lens and extreme focus to force saturation both ways
    write_reg(CFG_LENS, 32'hFFFF_FFFF);
    write_reg(CFG_FOCUS, 32'hFFFF_FFFF);
    push(32'h8000_0000, 32'hFFFF_FFFF, 16'd0);
    push(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
    drain();
    write_reg(CFG_FOCUS, 32'h8000_0000);
    push(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
    drain();
    // zero focus, then positive focus
    write_reg(CFG_FOCUS, 32'd0);
    push(32'hFFF0_0000, 32'hFFFF_FFFF, 16'd0);
    drain();
    write_reg(CFG_FOCUS, 32'h0001_0000);
    push(32'hFFF0_0000, 32'h0001_0000, 16'd0);
    drain();
    // artist with reset planes and full fractions
    write_reg(CFG_MODE, 32'd2);
    write_reg(CFG_FRACS, 32'hFFFF_FFFF);
    push(32'd0, 32'd0, 16'hFFFF);
    push(32'hFFFF_8000, 32'd0, 16'hFFFF);
    push(32'hFFF0_0000, 32'd0, 16'hFFFF);
    push(32'hFF80_0000, 32'd0, 16'hFFFF);
    push(32'h8000_0000, 32'd0, 16'hFFFF);
    drain();
    // degenerate ramps with overlapping planes
    write_reg(CFG_FRACS, 32'd0);
    write_reg(CFG_NEAR_SHRP, 32'hFFF0_0000);
    write_reg(CFG_NEAR_BLUR, 32'h8000_0000);
    write_reg(CFG_FAR_SHRP, 32'hFFFF_0000);
    write_reg(CFG_FAR_BLUR, 32'd0);
    push(32'hFFF8_0000, 32'd0, 16'd1000);
    push(32'hFFE0_0000, 32'd0, 16'd1000);
    drain();
    write_reg(CFG_FRACS, 32'h8000_4000);
    push(32'hFFF8_0000, 32'd0, 16'd1000);
    push(32'hFFE0_0000, 32'd0, 16'd1000);
    drain();
    // indexes past the register file are ignored
    for (int i = 8; i < 16; i++) write_reg(4'(i), $urandom);
    push(32'hFFF8_0000, 32'd0, 16'd1000);
    drain();

    for (int ph = 0; ph < 13; ph++) begin
      if (ph == 12) quiet = 1'b1;
      random_phase(70);
    end

    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

### sim.f
design/coc_pkg.sv
design/coc_front.sv
design/coc_div.sv
design/depth_of_field_coc_radius.sv
test/tb_top.sv
